[rtl/modexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

    // Width of every field on the ports
    localparam int FIELD_W = 64;
    // Three packed input fields
    localparam int S_DATA_W = 3 * FIELD_W;

    // Operand selection for one modular multiplication
    typedef enum logic [1:0] {
        MUL_REDUCE,  // base mod m: (1 mod m) * base
        MUL_ACC,     // acc * sq mod m
        MUL_SQ       // sq * sq mod m
    } mul_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;       // capture a new input word
        logic     mul_start;  // launch the shift-and-add multiplier
        mul_sel_t mul_sel;    // operands and destination for that launch
        logic     exp_shift;  // drop the consumed exponent bit
        logic     out_load;   // move the answer into the output register
    } modexp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
    } modexp_status_t;

endpackage

[rtl/modexp_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module modexp_mulmod import modexp_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WIDTH-1:0]     a_in,   // must be below m
    input  logic [WIDTH-1:0]     b_in,   // any value
    input  logic [WIDTH-1:0]     m_in,   // nonzero, held stable while busy
    output logic                 done,   // last step, prod valid this cycle
    output logic [WIDTH-1:0]     prod
);

    localparam int CW   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int TW   = WIDTH + 2;
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] p_reg, p_next;

    logic [TW-1:0]    t_sum;
    logic [TW-1:0]    m_one;
    logic [TW-1:0]    m_two;
    logic [WIDTH-1:0] p_step;

    // p = 2p + bit*a, then bring back below m (sum stays below 3m)
    always_comb begin
        t_sum = ({2'b00, p_reg} << 1) + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        m_one = {2'b00, m_in};
        m_two = {1'b0, m_in, 1'b0};
        if (t_sum >= m_two) begin
            p_step = WIDTH'(t_sum - m_two);
        end else if (t_sum >= m_one) begin
            p_step = WIDTH'(t_sum - m_one);
        end else begin
            p_step = t_sum[WIDTH-1:0];
        end
    end

    assign done = busy_reg && (cnt_reg == LAST);
    assign prod = p_step;

    // Operand and step counter update
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a_in;
            b_next    = b_in;
            p_next    = '0;
        end else if (busy_reg) begin
            p_next   = p_step;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

endmodule

[rtl/modexp_dp.sv]
// Datapath: operand registers, exponent shifter, multiplier and output register.
module modexp_dp import modexp_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  modexp_cmd_t         cmd,
    output modexp_status_t      status,
    output logic [FIELD_W-1:0]  m_tdata,
    output logic                m_tuser
);

    // Arithmetic runs on the low WIDTH bits, never wider than the fields
    localparam int DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

    logic [DW-1:0] exp_reg, exp_next;
    logic [DW-1:0] mod_reg, mod_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [DW-1:0] sq_reg, sq_next;
    mul_sel_t      dest_reg, dest_next;
    logic [FIELD_W-1:0] res_reg, res_next;
    logic          err_reg, err_next;

    logic [DW-1:0] one_mod;
    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic          mul_done;
    logic [DW-1:0] mul_prod;

    // 1 mod m, used to reduce the base
    assign one_mod = (mod_reg == DW'(1)) ? '0 : DW'(1);

    // Multiplier operand selection
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_REDUCE: begin
                mul_a = one_mod;
                mul_b = sq_reg;
            end
            MUL_ACC: begin
                mul_a = sq_reg;
                mul_b = acc_reg;
            end
            MUL_SQ: begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
            default: begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase
    end

    modexp_mulmod #(
        .WIDTH (DW)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .m_in    (mod_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // Register updates
    always_comb begin
        exp_next  = exp_reg;
        mod_next  = mod_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        dest_next = dest_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        if (cmd.load) begin
            sq_next  = s_tdata[DW-1:0];
            exp_next = s_tdata[FIELD_W +: DW];
            mod_next = s_tdata[2*FIELD_W +: DW];
            acc_next = DW'(1);
        end
        if (cmd.mul_start) begin
            dest_next = cmd.mul_sel;
        end
        // Product write-back on the last multiplier step
        if (mul_done) begin
            case (dest_reg)
                MUL_ACC: acc_next = mul_prod;
                default: sq_next  = mul_prod;
            endcase
        end
        if (cmd.exp_shift) begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.out_load) begin
            err_next = (mod_reg == '0);
            res_next = (mod_reg == '0) ? '0 : FIELD_W'(acc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        dest_reg <= dest_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign status.mod_zero = (mod_reg == '0);
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.mul_done = mul_done;

    assign m_tdata = res_reg;
    assign m_tuser = err_reg;

endmodule

[rtl/modexp_ctrl.sv]
// Controller: sequences base reduction, square-and-multiply passes and output.
module modexp_ctrl import modexp_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  modexp_status_t status,
    output modexp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_SQ;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.mod_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_REDUCE;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.mul_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.exp_zero) begin
                    state_next = ST_OUT;
                end else if (status.exp_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_ACC;
                    state_next    = ST_MUL_ACC;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SQ;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC: begin
                if (status.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SQ;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: begin
                if (status.mul_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/modular_exponentiation.sv]
// Modular exponentiation top level: base ** exponent mod modulus per word.
//
// Each input word carries a base, an exponent and a modulus; one result word
// comes back with the residue and an error flag that is set (residue 0) when
// the modulus is zero. An exponent of zero gives 1 for any nonzero modulus.
// Work uses the low min(WIDTH,64) bits (DW) of each field. One word is worked
// at a time, right-to-left square-and-multiply, every modular product done by
// a bit-serial shift-and-add multiplier. The next input word is taken while a
// finished result still waits in the output register.
module modular_exponentiation import modexp_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // base_value, exponent, modulus
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [FIELD_W-1:0]  m_tdata,   // residue
    output logic                m_tuser    // modulus_error
);

    modexp_cmd_t    cmd;
    modexp_status_t status;

    modexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

[sim/tb_modular_exponentiation.sv]
// Self-checking testbench for the modular exponentiation block.
module tb_modular_exponentiation import modexp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUT_WIDTH = 64;
    // Work width of the arithmetic: low bits of each field that are used
    localparam int DW = (DUT_WIDTH < 64) ? DUT_WIDTH : 64;
    // Cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 60000;
    // Extra cycles after the last expected word, to catch stray results
    localparam int DRAIN_CYCLES = 100;

    // Input word, last field (base_value) in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] base_value;
    } operand_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] residue;
        logic               modulus_error;
    } power_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [FIELD_W-1:0]  m_tdata;
    logic                m_tuser;

    power_result_t expected_results[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;
    int            quiet_cycles   = 0;

    modular_exponentiation #(
        .WIDTH(DUT_WIDTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Exact a * b mod m through a double-width product
    function automatic logic [63:0] mul_mod_exact(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] m);
        logic [127:0] product;
        product = {64'd0, a} * {64'd0, b};
        return 64'(product % {64'd0, m});
    endfunction

    // Expected answer for one input word: base ** exponent mod modulus
    function automatic power_result_t predict_power(operand_word_t w);
        logic [63:0]   mask;
        logic [63:0]   square;
        logic [63:0]   exp_left;
        logic [63:0]   modv;
        logic [63:0]   acc;
        power_result_t r;
        mask     = (DW >= 64) ? '1 : ((64'd1 << DW) - 64'd1);
        square   = w.base_value & mask;
        exp_left = w.exponent & mask;
        modv     = w.modulus & mask;
        acc      = 64'd1;
        if (modv == 64'd0) begin
            r.residue       = '0;
            r.modulus_error = 1'b1;
            return r;
        end
        // right-to-left square-and-multiply
        while (exp_left != 64'd0) begin
            if (exp_left[0]) begin
                acc = mul_mod_exact(acc, square, modv);
            end
            square   = mul_mod_exact(square, square, modv);
            exp_left = exp_left >> 1;
        end
        r.residue       = acc;
        r.modulus_error = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Send one word; entered and left just after a falling edge
    task automatic send_word(input logic [63:0] base_value, input logic [63:0] exponent,
                             input logic [63:0] modulus);
        operand_word_t w;
        w.base_value = base_value;
        w.exponent   = exponent;
        w.modulus    = modulus;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_power(w));
        @(negedge aclk);
    endtask

    // Zero modulus, zero exponent, modulus one, base not below modulus
    task automatic test_special_cases();
        send_word(64'd12345, 64'd0, 64'd0);
        send_word('1, '1, 64'd0);
        send_word(64'd5, 64'd77, 64'd0);
        send_word(64'd9, 64'd0, 64'd1);
        send_word('1, 64'd0, '1);
        send_word(64'd0, 64'd0, 64'd7);
        send_word(64'd0, 64'd3, 64'd7);
        send_word(64'd123456, 64'd5, 64'd1);
        send_word('1, 64'd5, 64'd97);
        send_word(64'd97, 64'd13, 64'd97);
        send_word(64'd1000, 64'd3, 64'd999);
    endtask

    // Field extremes, including exponents with every bit set
    task automatic test_field_extremes();
        send_word('1, '1, '1);
        send_word('1, '1, 64'hFFFF_FFFF_FFFF_FFC5);
        send_word(64'd2, 64'd63, '1);
        send_word(64'hFFFF_FFFF_FFFF_FFFE, 64'd2, '1);
        send_word(64'd3, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5);
        send_word(64'h8000_0000_0000_0001, 64'd1, 64'h8000_0000_0000_0000);
        send_word(64'd7, 64'd10, 64'd2);
        send_word(64'h0123_4567_89AB_CDEF, 64'd1, '1);
    endtask

    // Random words: mostly short exponents, a few full width ones, some zero moduli
    task automatic test_random_words(input int count);
        logic [63:0] base_value;
        logic [63:0] exponent;
        logic [63:0] modulus;
        repeat (count) begin
            base_value = rand64();
            if ($urandom_range(3) == 0) begin
                base_value = base_value >> $urandom_range(63);
            end
            if ($urandom_range(9) == 0) begin
                exponent = rand64();
            end else begin
                exponent = 64'($urandom_range(65535) >> $urandom_range(15));
            end
            modulus = rand64();
            if ($urandom_range(1) == 0) begin
                modulus = modulus >> $urandom_range(63);
            end
            if ($urandom_range(15) == 0) begin
                modulus = '0;
            end
            send_word(base_value, exponent, modulus);
        end
    endtask

    // Result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        power_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word residue %h error %b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (m_tdata !== want.residue) begin
                    $display("%0t: residue expected %h actual %h",
                             $time, want.residue, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.modulus_error) begin
                    $display("%0t: modulus_error expected %b actual %b",
                             $time, want.modulus_error, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout at %0t", $time);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 59;
        test_special_cases();
        test_field_extremes();
        test_random_words(27);

        send_idle_pct = 59;
        recv_idle_pct = 30;
        test_random_words(27);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_words(27);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modexp_dp.sv
rtl/modexp_ctrl.sv
rtl/modular_exponentiation.sv
sim/tb_modular_exponentiation.sv
